>>> hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression must never be true at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

>>> hw/rtl/wcf_pkg.sv
// Types, constants and CRC / whitening functions of the packet framer.
package wcf_pkg;

  localparam int unsigned PAYLOAD_MAX_DEF = 32;

  localparam logic [15:0] CRC_POLY  = 16'h8005;
  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [8:0]  LFSR_INIT = 9'h1FF;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_NETWORK_ID = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_CAP = 1'b1;
  localparam logic [5:0] CAP_RESET = 6'd12;

  localparam logic [2:0] KIND_LENGTH  = 3'd0;
  localparam logic [2:0] KIND_NETID   = 3'd1;
  localparam logic [2:0] KIND_PAYLOAD = 3'd2;
  localparam logic [2:0] KIND_CRC     = 3'd3;
  localparam logic [2:0] KIND_PAD     = 3'd4;

  typedef enum logic [2:0] {
    PH_START,
    PH_LEN,
    PH_NID_HI,
    PH_NID_LO,
    PH_DATA,
    PH_CRC_HI,
    PH_CRC_LO,
    PH_PAD
  } phase_e;

  typedef struct packed {
    logic       action;
    logic [7:0] data_length;
    logic [7:0] data_byte;
  } item_t;

  // CRC-16, polynomial 0x8005, MSB first, one byte.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  // PN9 (x^9 + x^5 + 1), eight right-shift steps.
  function automatic logic [8:0] pn9_advance(input logic [8:0] lfsr);
    logic [8:0] r;
    r = lfsr;
    for (int k = 0; k < 8; k++) begin
      r = {r[0] ^ r[5], r[8:1]};
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/wcf_if.sv
// Valid/ready stream interfaces for the framer's input items and output bytes.
interface wcf_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] data_length;
  logic [7:0] data_byte;

  modport source (output valid, action, data_length, data_byte, input ready);
  modport sink (input valid, action, data_length, data_byte, output ready);
endinterface

interface wcf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic [2:0] byte_kind;
  logic       packet_last;

  modport source (output valid, tx_byte, byte_kind, packet_last, input ready);
  modport sink (input valid, tx_byte, byte_kind, packet_last, output ready);
endinterface

>>> hw/rtl/wcf_in_stage.sv
// Input register: holds the item under work until the engine releases it.
module wcf_in_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  wcf_in_if.sink           in_i,
  output logic             item_valid_o,
  output wcf_pkg::item_t   item_o,
  input  logic             item_pop_i
);

  logic           valid_q, valid_d;
  wcf_pkg::item_t item_q;
  logic           accept;

  assign in_i.ready = !valid_q || item_pop_i;
  assign accept     = in_i.valid && in_i.ready;
  assign valid_d    = accept || (valid_q && !item_pop_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= '{action: in_i.action, data_length: in_i.data_length,
                  data_byte: in_i.data_byte};
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

>>> hw/rtl/wcf_engine.sv
// Byte engine: one byte a cycle unless stalled; CRC, whitening, output register.
module wcf_engine #(
  parameter int unsigned PAYLOAD_MAX = wcf_pkg::PAYLOAD_MAX_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           item_valid_i,
  input  wcf_pkg::item_t item_i,
  output logic           item_pop_o,
  input  logic [15:0]    network_id_i,
  input  logic [5:0]     payload_capacity_i,
  wcf_out_if.source      out_o
);

  wcf_pkg::phase_e phase_q, phase_d, ph;
  logic [15:0] crc_q, crc_d, crc_cur;
  logic [8:0]  lfsr_q, lfsr_d, lfsr_cur;
  logic [5:0]  left_q, left_d;
  logic [5:0]  npay_q, npay_d;
  logic [5:0]  pad_q, pad_d;
  logic        open_q, open_d;

  logic        out_valid_q, out_valid_d;
  logic [7:0]  tx_byte_q;
  logic [2:0]  kind_q;
  logic        last_q;

  logic        out_free, fire;
  logic [5:0]  cap_eff, n_clamp;
  logic [7:0]  raw_byte;
  logic [2:0]  kind;
  logic        emit, covered, last, done;

  assign out_free = !out_valid_q || out_o.ready;
  assign fire     = item_valid_i && out_free;

  assign cap_eff = (payload_capacity_i > 6'(PAYLOAD_MAX)) ? 6'(PAYLOAD_MAX)
                                                          : payload_capacity_i;
  assign n_clamp = (item_i.data_length < {2'b00, cap_eff}) ? item_i.data_length[5:0]
                                                           : cap_eff;

  // A fresh item starts at the length byte or at a payload byte.
  always_comb begin
    if (phase_q == wcf_pkg::PH_START) begin
      if (item_i.action) begin
        ph = wcf_pkg::PH_DATA;
      end else begin
        ph = wcf_pkg::PH_LEN;
      end
    end else begin
      ph = phase_q;
    end
  end

  assign lfsr_cur = (ph == wcf_pkg::PH_LEN) ? wcf_pkg::LFSR_INIT : lfsr_q;
  assign crc_cur  = (ph == wcf_pkg::PH_LEN) ? wcf_pkg::CRC_INIT : crc_q;

  // Next phase and per-byte decode.
  always_comb begin
    phase_d  = phase_q;
    left_d   = left_q;
    npay_d   = npay_q;
    pad_d    = pad_q;
    open_d   = open_q;
    raw_byte = 8'h00;
    kind     = wcf_pkg::KIND_PAD;
    emit     = 1'b0;
    covered  = 1'b0;
    last     = 1'b0;
    done     = 1'b0;
    case (ph)
      wcf_pkg::PH_LEN: begin
        raw_byte = {2'b00, n_clamp} + 8'd2;
        kind     = wcf_pkg::KIND_LENGTH;
        emit     = 1'b1;
        covered  = 1'b1;
        left_d   = n_clamp;
        npay_d   = n_clamp;
        open_d   = 1'b0;
        phase_d  = wcf_pkg::PH_NID_HI;
      end
      wcf_pkg::PH_NID_HI: begin
        raw_byte = network_id_i[15:8];
        kind     = wcf_pkg::KIND_NETID;
        emit     = 1'b1;
        covered  = 1'b1;
        phase_d  = wcf_pkg::PH_NID_LO;
      end
      wcf_pkg::PH_NID_LO: begin
        raw_byte = network_id_i[7:0];
        kind     = wcf_pkg::KIND_NETID;
        emit     = 1'b1;
        covered  = 1'b1;
        if (left_q == '0) begin
          phase_d = wcf_pkg::PH_CRC_HI;
        end else begin
          open_d  = 1'b1;
          done    = 1'b1;
          phase_d = wcf_pkg::PH_START;
        end
      end
      wcf_pkg::PH_DATA: begin
        raw_byte = item_i.data_byte;
        kind     = wcf_pkg::KIND_PAYLOAD;
        if (!open_q) begin
          // Drop surplus payload.
          done    = 1'b1;
          phase_d = wcf_pkg::PH_START;
        end else begin
          emit    = 1'b1;
          covered = 1'b1;
          left_d  = left_q - 6'd1;
          if (left_q == 6'd1) begin
            phase_d = wcf_pkg::PH_CRC_HI;
          end else begin
            done    = 1'b1;
            phase_d = wcf_pkg::PH_START;
          end
        end
      end
      wcf_pkg::PH_CRC_HI: begin
        raw_byte = crc_q[15:8];
        kind     = wcf_pkg::KIND_CRC;
        emit     = 1'b1;
        pad_d    = (cap_eff > npay_q) ? cap_eff - npay_q : '0;
        phase_d  = wcf_pkg::PH_CRC_LO;
      end
      wcf_pkg::PH_CRC_LO: begin
        raw_byte = crc_q[7:0];
        kind     = wcf_pkg::KIND_CRC;
        emit     = 1'b1;
        if (pad_q == '0) begin
          last    = 1'b1;
          done    = 1'b1;
          open_d  = 1'b0;
          left_d  = '0;
          phase_d = wcf_pkg::PH_START;
        end else begin
          phase_d = wcf_pkg::PH_PAD;
        end
      end
      wcf_pkg::PH_PAD: begin
        raw_byte = 8'h00;
        kind     = wcf_pkg::KIND_PAD;
        emit     = 1'b1;
        pad_d    = pad_q - 6'd1;
        if (pad_q == 6'd1) begin
          last    = 1'b1;
          done    = 1'b1;
          open_d  = 1'b0;
          left_d  = '0;
          phase_d = wcf_pkg::PH_START;
        end
      end
      default: begin
        phase_d = wcf_pkg::PH_START;
      end
    endcase
  end

  assign item_pop_o  = fire && done;
  assign lfsr_d      = (fire && emit) ? wcf_pkg::pn9_advance(lfsr_cur) : lfsr_q;
  assign crc_d       = (fire && covered) ? wcf_pkg::crc16_byte(crc_cur, raw_byte) : crc_q;
  assign out_valid_d = out_free ? (fire && emit) : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= wcf_pkg::PH_START;
      crc_q       <= wcf_pkg::CRC_INIT;
      lfsr_q      <= wcf_pkg::LFSR_INIT;
      left_q      <= '0;
      npay_q      <= '0;
      pad_q       <= '0;
      open_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      crc_q       <= crc_d;
      lfsr_q      <= lfsr_d;
      if (fire) begin
        phase_q <= phase_d;
        left_q  <= left_d;
        npay_q  <= npay_d;
        pad_q   <= pad_d;
        open_q  <= open_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && emit) begin
      tx_byte_q <= raw_byte ^ lfsr_cur[7:0];
      kind_q    <= kind;
      last_q    <= last;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.tx_byte     = tx_byte_q;
  assign out_o.byte_kind   = kind_q;
  assign out_o.packet_last = last_q;

endmodule

>>> hw/rtl/whitened_crc_packet_framer.sv
// Whitened CRC-16 packet framer, top level.
//
// Input channel in_i carries items: action 0 begins a packet of data_length
// payload bytes (clamped to the capacity), action 1 supplies one payload byte.
// Output channel out_o carries whitened bytes with their kind and a last flag.
// Both are valid/ready; a transaction completes when valid and ready are high.
// Configuration writes (network id, payload capacity) go through cfg_we_i,
// cfg_idx_i and cfg_wdata_i only while the block is idle; the user must keep
// to this, as the block does not enforce it. An item's first byte goes through
// the input register, then the output register. Bytes leave one per cycle
// while the receiver is ready. An item holds the input register until the
// engine is done with it: a begin yields length and network id bytes, a payload
// item its byte, each plus CRC and padding if it ends the packet; surplus none.
// Reset clears the CRC to 0xFFFF, the whitening LFSR to 0x1FF, closes any
// packet, and sets the network id to 0 and the capacity to 12.
// When the receiver stalls, the output register holds its byte, the engine
// waits, and in_i drops ready once the input register is occupied.
module whitened_crc_packet_framer #(
  parameter int unsigned PAYLOAD_MAX = wcf_pkg::PAYLOAD_MAX_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  wcf_in_if.sink                         in_i,
  wcf_out_if.source                      out_o,
  input  logic                           cfg_we_i,
  input  logic [wcf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [wcf_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  logic [15:0]    network_id_q;
  logic [5:0]     payload_capacity_q;
  logic           item_valid;
  logic           item_pop;
  wcf_pkg::item_t item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      network_id_q       <= '0;
      payload_capacity_q <= wcf_pkg::CAP_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        wcf_pkg::CFG_NETWORK_ID:  network_id_q       <= cfg_wdata_i[15:0];
        wcf_pkg::CFG_PAYLOAD_CAP: payload_capacity_q <= cfg_wdata_i[5:0];
        default: ;
      endcase
    end
  end

  wcf_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_pop_i   (item_pop)
  );

  wcf_engine #(
    .PAYLOAD_MAX (PAYLOAD_MAX)
  ) u_engine (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .item_valid_i       (item_valid),
    .item_i             (item),
    .item_pop_o         (item_pop),
    .network_id_i       (network_id_q),
    .payload_capacity_i (payload_capacity_q),
    .out_o              (out_o)
  );

endmodule

>>> hw/rtl/wcf_checker.sv
// Port-level checker for the packet framer, with its bind.
`include "assert_macros.svh"

module wcf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] tx_byte,
  input logic [2:0] byte_kind,
  input logic       packet_last
);

  `ASSERT_PROP(a_stall_hold, clk_i, rst_ni, (out_valid && !out_ready) |=> (out_valid && $stable(tx_byte) && $stable(byte_kind) && $stable(packet_last)), "stalled byte changed")

  `ASSERT_NEVER(a_kind_range, clk_i, rst_ni, out_valid && (byte_kind > wcf_pkg::KIND_PAD), "byte kind out of range")

  `ASSERT_PROP(a_last_kind, clk_i, rst_ni, (out_valid && packet_last) |-> (byte_kind == wcf_pkg::KIND_CRC || byte_kind == wcf_pkg::KIND_PAD), "packet ends on a header or payload byte")

  `ASSERT_PROP(a_len_then_nid, clk_i, rst_ni, (out_valid && out_ready && byte_kind == wcf_pkg::KIND_LENGTH) |=> (out_valid && byte_kind == wcf_pkg::KIND_NETID), "length byte not followed by network id")

endmodule

bind whitened_crc_packet_framer wcf_checker u_wcf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid   (out_o.valid),
  .out_ready   (out_o.ready),
  .tx_byte     (out_o.tx_byte),
  .byte_kind   (out_o.byte_kind),
  .packet_last (out_o.packet_last)
);

>>> verif/tb.sv
`timescale 1ns / 100ps
// Testbench for the whitened CRC-16 packet framer: directed and random packets checked per byte.
module tb;

  localparam int unsigned PMAX        = wcf_pkg::PAYLOAD_MAX_DEF;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_CYCLES = 150;

  localparam logic ACT_BEGIN   = 1'b0;
  localparam logic ACT_PAYLOAD = 1'b1;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic [2:0] kind;
    logic       last;
  } frame_byte_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [wcf_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [wcf_pkg::CFG_DATA_W-1:0] cfg_wdata_i;

  wcf_in_if  in_if ();
  wcf_out_if out_if ();

  whitened_crc_packet_framer #(.PAYLOAD_MAX(PMAX)) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // Predicted framer state and register copies
  logic [15:0] crc_acc;
  logic [8:0]  pn9_state;
  logic [5:0]  byte_pos;
  logic [5:0]  payload_left;
  logic        pkt_open;
  logic [15:0] net_id;
  logic [5:0]  cap_setting;

  frame_byte_t framed_q[$];
  frame_byte_t want_byte;

  int unsigned errors = 0;
  int unsigned items_sent = 0;
  int unsigned bytes_checked = 0;
  int unsigned packets_closed = 0;
  int unsigned cycles = 0;
  bit          idle_en = 1'b0;
  bit          hold_req = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d bytes still expected", $time, framed_q.size());
      $display("tb: FAIL");
      $finish;
    end
  end

  function automatic logic [5:0] cap_in_use();
    return (cap_setting > PMAX) ? 6'(PMAX) : cap_setting;
  endfunction

  // Whiten one byte, fold it into the CRC if covered, and queue it.
  task automatic push_frame_byte(input logic [7:0] b, input logic [2:0] kind, input bit covered);
    logic [7:0]  mask;
    logic [15:0] c;
    frame_byte_t fb;
    mask = pn9_state[7:0];
    for (int k = 0; k < 8; k++) begin
      pn9_state = {pn9_state[0] ^ pn9_state[5], pn9_state[8:1]};
    end
    if (covered) begin
      c = crc_acc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
        c = c[15] ? ({c[14:0], 1'b0} ^ wcf_pkg::CRC_POLY) : {c[14:0], 1'b0};
      end
      crc_acc = c;
    end
    fb.tx_byte = b ^ mask;
    fb.kind    = kind;
    fb.last    = 1'b0;
    framed_q.push_back(fb);
    byte_pos = byte_pos + 6'd1;
  endtask

  // Append CRC and padding, then flag the final byte.
  task automatic close_packet();
    frame_byte_t fb;
    logic [5:0]  sent;
    logic [5:0]  limit;
    logic [5:0]  pad;
    logic [15:0] crc_snap;
    sent     = byte_pos - 6'd3;
    limit    = cap_in_use();
    pad      = (limit > sent) ? limit - sent : 6'd0;
    crc_snap = crc_acc;
    push_frame_byte(crc_snap[15:8], wcf_pkg::KIND_CRC, 1'b0);
    push_frame_byte(crc_snap[7:0], wcf_pkg::KIND_CRC, 1'b0);
    for (int i = 0; i < pad; i++) begin
      push_frame_byte(8'h00, wcf_pkg::KIND_PAD, 1'b0);
    end
    fb = framed_q.pop_back();
    fb.last = 1'b1;
    framed_q.push_back(fb);
    pkt_open     = 1'b0;
    payload_left = 6'd0;
    packets_closed++;
  endtask

  task automatic frame_item(input logic action, input logic [7:0] len, input logic [7:0] data);
    logic [5:0] n;
    if (action == ACT_BEGIN) begin
      n = (len < cap_in_use()) ? len[5:0] : cap_in_use();
      crc_acc   = wcf_pkg::CRC_INIT;
      pn9_state = wcf_pkg::LFSR_INIT;
      byte_pos  = 6'd0;
      push_frame_byte({2'b00, n} + 8'd2, wcf_pkg::KIND_LENGTH, 1'b1);
      push_frame_byte(net_id[15:8], wcf_pkg::KIND_NETID, 1'b1);
      push_frame_byte(net_id[7:0], wcf_pkg::KIND_NETID, 1'b1);
      payload_left = n;
      pkt_open     = 1'b1;
      if (n == 6'd0) close_packet();
    end else if (pkt_open) begin
      push_frame_byte(data, wcf_pkg::KIND_PAYLOAD, 1'b1);
      payload_left = payload_left - 6'd1;
      if (payload_left == 6'd0) close_packet();
    end
  endtask

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_item(input logic action, input logic [7:0] len, input logic [7:0] data);
    int unsigned gap;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid       = 1'b1;
    in_if.action      = action;
    in_if.data_length = len;
    in_if.data_byte   = data;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    if (action == ACT_BEGIN || pkt_open) items_sent++;
    frame_item(action, len, data);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_if.valid = 1'b0;
    while (framed_q.size() != 0) @(negedge clk_i);
    // allow an ignored payload item to clear the engine
    repeat (10) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [wcf_pkg::CFG_IDX_W-1:0] idx, input logic [15:0] value);
    wait_drained();
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = value;
    @(posedge clk_i);
    if (idx == wcf_pkg::CFG_NETWORK_ID) net_id = value;
    else cap_setting = value[5:0];
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic raise_hold_off();
    @(posedge clk_i);
    hold_req = 1'b1;
    @(negedge clk_i);
  endtask

  // Receiver: random stall bursts, plus a long hold-off on request.
  initial begin
    int unsigned stall;
    stall = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_if.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      if (stall > 0) begin
        out_if.ready = 1'b0;
        stall--;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(0, 11);
        out_if.ready = 1'b0;
      end else begin
        out_if.ready = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (framed_q.size() == 0) begin
        $display("%0t: unexpected byte: expected none, got tx_byte %02h kind %0d last %0b",
                 $time, out_if.tx_byte, out_if.byte_kind, out_if.packet_last);
        errors++;
      end else begin
        want_byte = framed_q.pop_front();
        bytes_checked++;
        if (out_if.tx_byte !== want_byte.tx_byte) begin
          $display("%0t: tx_byte mismatch: expected %02h, got %02h",
                   $time, want_byte.tx_byte, out_if.tx_byte);
          errors++;
        end
        if (out_if.byte_kind !== want_byte.kind) begin
          $display("%0t: byte_kind mismatch: expected %0d, got %0d",
                   $time, want_byte.kind, out_if.byte_kind);
          errors++;
        end
        if (out_if.packet_last !== want_byte.last) begin
          $display("%0t: packet_last mismatch: expected %0b, got %0b",
                   $time, want_byte.last, out_if.packet_last);
          errors++;
        end
      end
    end
  end

  task automatic test_reset_defaults();
    send_item(ACT_BEGIN, 8'd0, 8'h00);
    send_item(ACT_BEGIN, 8'd3, 8'h5A);
    send_item(ACT_PAYLOAD, 8'hFF, 8'h00);
    send_item(ACT_PAYLOAD, 8'h00, 8'hFF);
    send_item(ACT_PAYLOAD, 8'hA5, 8'hA5);
  endtask

  task automatic test_register_extremes();
    write_reg(wcf_pkg::CFG_NETWORK_ID, 16'hFFFF);
    write_reg(wcf_pkg::CFG_PAYLOAD_CAP, 16'd0);
    send_item(ACT_BEGIN, 8'hFF, 8'h00);
    // capacity above the maximum pads out to the maximum
    write_reg(wcf_pkg::CFG_PAYLOAD_CAP, 16'd63);
    write_reg(wcf_pkg::CFG_NETWORK_ID, 16'h0000);
    send_item(ACT_BEGIN, 8'd0, 8'h00);
    write_reg(wcf_pkg::CFG_PAYLOAD_CAP, 16'd1);
    write_reg(wcf_pkg::CFG_NETWORK_ID, 16'hA55A);
    send_item(ACT_BEGIN, 8'd255, 8'h00);
    send_item(ACT_PAYLOAD, 8'h00, 8'h81);
    write_reg(wcf_pkg::CFG_PAYLOAD_CAP, 16'd32);
    send_item(ACT_BEGIN, 8'd33, 8'h00);
  endtask

  task automatic test_surplus_and_restart();
    // drop the packet left open above
    send_item(ACT_BEGIN, 8'd2, 8'h00);
    send_item(ACT_PAYLOAD, 8'h12, 8'h3C);
    send_item(ACT_PAYLOAD, 8'h34, 8'hC3);
    send_item(ACT_PAYLOAD, 8'h56, 8'h77);
    send_item(ACT_PAYLOAD, 8'h78, 8'h88);
    send_item(ACT_BEGIN, 8'd4, 8'h00);
    send_item(ACT_PAYLOAD, 8'h00, 8'h01);
    send_item(ACT_PAYLOAD, 8'h00, 8'h80);
    send_item(ACT_BEGIN, 8'd1, 8'h00);
    send_item(ACT_PAYLOAD, 8'h00, 8'h7E);
  endtask

  task automatic test_capacity_mid_packet();
    write_reg(wcf_pkg::CFG_PAYLOAD_CAP, 16'd8);
    send_item(ACT_BEGIN, 8'd4, 8'h00);
    send_item(ACT_PAYLOAD, 8'h00, 8'hDE);
    // capacity below the latched count: no padding
    write_reg(wcf_pkg::CFG_PAYLOAD_CAP, 16'd2);
    send_item(ACT_PAYLOAD, 8'h00, 8'hAD);
    send_item(ACT_PAYLOAD, 8'h00, 8'hBE);
    send_item(ACT_PAYLOAD, 8'h00, 8'hEF);
    write_reg(wcf_pkg::CFG_PAYLOAD_CAP, 16'd4);
    send_item(ACT_BEGIN, 8'd2, 8'h00);
    send_item(ACT_PAYLOAD, 8'h00, 8'h55);
    write_reg(wcf_pkg::CFG_PAYLOAD_CAP, 16'd20);
    send_item(ACT_PAYLOAD, 8'h00, 8'hAA);
  endtask

  task automatic test_backpressure();
    write_reg(wcf_pkg::CFG_PAYLOAD_CAP, 16'd32);
    raise_hold_off();
    send_item(ACT_BEGIN, 8'd24, 8'($urandom));
    for (int k = 0; k < 24; k++) begin
      send_item(ACT_PAYLOAD, 8'($urandom), 8'($urandom));
    end
  endtask

  // Mostly whole packets with random content; some noise, cut-short and surplus sequences.
  task automatic test_random_packets(input int unsigned target);
    int unsigned goal;
    int unsigned pick;
    int unsigned n;
    logic [15:0] capv;
    logic [7:0]  len;
    goal = items_sent + target;
    while (items_sent < goal) begin
      pick = $urandom_range(0, 11);
      if (pick == 0) begin
        if ($urandom_range(0, 1) == 1) begin
          write_reg(wcf_pkg::CFG_NETWORK_ID, 16'($urandom_range(0, 65535)));
        end else begin
          case ($urandom_range(0, 5))
            0: capv = 16'd0;
            1: capv = 16'd32;
            2: capv = 16'd63;
            default: capv = 16'($urandom_range(1, 16));
          endcase
          write_reg(wcf_pkg::CFG_PAYLOAD_CAP, capv);
        end
      end else if (pick == 1) begin
        send_item(ACT_PAYLOAD, 8'($urandom), 8'($urandom));
      end else begin
        len = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 8));
        send_item(ACT_BEGIN, len, 8'($urandom));
        n = 32'(payload_left);
        if (pick == 2 && n > 0) n = $urandom_range(0, n - 1);
        for (int k = 0; k < n; k++) begin
          send_item(ACT_PAYLOAD, 8'($urandom), 8'($urandom));
        end
        if (pick == 3) send_item(ACT_PAYLOAD, 8'($urandom), 8'($urandom));
      end
    end
  endtask

  initial begin
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = '0;
    cfg_wdata_i       = '0;
    in_if.valid       = 1'b0;
    in_if.action      = ACT_BEGIN;
    in_if.data_length = 8'h00;
    in_if.data_byte   = 8'h00;
    crc_acc           = wcf_pkg::CRC_INIT;
    pn9_state         = wcf_pkg::LFSR_INIT;
    byte_pos          = 6'd0;
    payload_left      = 6'd0;
    pkt_open          = 1'b0;
    net_id            = 16'h0000;
    cap_setting       = wcf_pkg::CAP_RESET;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    idle_en = 1'b1;
    test_reset_defaults();
    test_register_extremes();
    test_surplus_and_restart();
    test_capacity_mid_packet();
    test_backpressure();
    test_random_packets(50);
    idle_en = 1'b0;
    test_random_packets(20);

    wait_drained();
    repeat (20) @(negedge clk_i);
    $display("summary: %0d items accepted, %0d bytes checked over %0d packets, %0d errors",
             items_sent, bytes_checked, packets_closed, errors);
    $display("summary: empty, clamped, dropped, cut-short and surplus payloads, capacity %s",
             "changes mid-packet and a long receiver hold-off");
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
